// ===== hdl/signature_packet_parser_macros.svh =====
// ----------------------------------------------------------------------------
// signature_packet_parser_macros.svh
// assertion macros shared by the signature packet parser modules
// ----------------------------------------------------------------------------
`ifndef SIGNATURE_PACKET_PARSER_MACROS_SVH
`define SIGNATURE_PACKET_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define SPP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spp assertion failed");

// antecedent implies consequent in the next cycle
`define SPP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spp assertion failed");

`else

`define SPP_ASSERT_IMP(lbl, ante, cons)
`define SPP_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/spp_pkg.sv =====
// ----------------------------------------------------------------------------
// spp_pkg
// types and constants of the signature packet parser
// ----------------------------------------------------------------------------
package spp_pkg;

  // format constants
  localparam logic [3:0] MinBody       = 4'd12;
  localparam logic [7:0] TwoOctetMark  = 8'd192;
  localparam logic [7:0] FiveOctetMark = 8'd255;
  localparam logic [16:0] HashedFixed  = 17'd6;
  localparam logic [7:0] VersionFour   = 8'd4;
  localparam logic [7:0] AlgRsa        = 8'd1;
  localparam logic [7:0] SubTime       = 8'd2;
  localparam logic [7:0] SubIssuer     = 8'd16;
  localparam logic [2:0] Len5Bytes     = 3'd4;

  // result queue geometry
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // summary status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_SHORT       = 3'd1;
  localparam logic [2:0] ST_OVERRUN     = 3'd2;
  localparam logic [2:0] ST_BAD_SUBLEN  = 3'd3;
  localparam logic [2:0] ST_BAD_VERSION = 3'd4;
  localparam logic [2:0] ST_BAD_ALG     = 3'd5;

  // result kinds
  localparam logic KIND_VALUE   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // top-level parse phase
  typedef enum logic [15:0] {
    PH_VER   = 16'h0001,
    PH_TYPE  = 16'h0002,
    PH_PKA   = 16'h0004,
    PH_HASH  = 16'h0008,
    PH_HLEN0 = 16'h0010,
    PH_HLEN1 = 16'h0020,
    PH_ULEN0 = 16'h0040,
    PH_ULEN1 = 16'h0080,
    PH_AREA  = 16'h0100,
    PH_CHK0  = 16'h0200,
    PH_CHK1  = 16'h0400,
    PH_BITS0 = 16'h0800,
    PH_BITS1 = 16'h1000,
    PH_VALUE = 16'h2000,
    PH_DONE  = 16'h4000,
    PH_HALT  = 16'h8000
  } spp_phase_e;

  // position inside a subpacket
  typedef enum logic [4:0] {
    SUB_LEN0 = 5'h01,
    SUB_LEN2 = 5'h02,
    SUB_LEN5 = 5'h04,
    SUB_KIND = 5'h08,
    SUB_BODY = 5'h10
  } spp_sub_e;

  // one result item
  typedef struct packed {
    logic        kind;
    logic [7:0]  value_byte;
    logic        value_final;
    logic [7:0]  signature_class;
    logic [7:0]  key_algorithm;
    logic [7:0]  digest_algorithm;
    logic [31:0] made_at;
    logic [63:0] issuer_id;
    logic [15:0] quick_check;
    logic [16:0] hashed_length;
    logic [2:0]  status;
  } spp_result_t;

  // results produced by one processed item
  typedef struct packed {
    logic value;
    logic summary;
  } spp_push_t;

endpackage

// ===== hdl/spp_fifo.sv =====
// ----------------------------------------------------------------------------
// spp_fifo
// result queue: takes up to two results a cycle and, while the output is not stalled, gives one a cycle
// ----------------------------------------------------------------------------
`include "signature_packet_parser_macros.svh"

module spp_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spp_pkg::spp_push_t  push_i,
  input  spp_pkg::spp_result_t val_res_i,
  input  spp_pkg::spp_result_t sum_res_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output spp_pkg::spp_result_t out_res_o
);

  spp_pkg::spp_result_t mem_q [spp_pkg::FifoDepth];
  logic [spp_pkg::FifoPtrW-1:0] wptr_q, wptr_d, wptr_nx, rptr_q, rptr_d;
  logic [spp_pkg::FifoCntW-1:0] count_q, count_d, push_cnt;
  logic                         pop;
  logic                         wr0_en, wr1_en;
  spp_pkg::spp_result_t         wr0_data;

  // room for a full pair of results
  assign room_o      = count_q <= spp_pkg::FifoCntW'(spp_pkg::FifoDepth - 2);
  assign out_valid_o = count_q != '0;
  assign out_res_o   = mem_q[rptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  // write ports: value result goes first when both come
  always_comb begin
    wr0_en   = push_i.value || push_i.summary;
    wr1_en   = push_i.value && push_i.summary;
    wr0_data = push_i.value ? val_res_i : sum_res_i;
    push_cnt = spp_pkg::FifoCntW'(push_i.value) + spp_pkg::FifoCntW'(push_i.summary);
    wptr_nx  = wptr_q + spp_pkg::FifoPtrW'(1);
    wptr_d   = wptr_q + spp_pkg::FifoPtrW'(push_cnt);
    rptr_d   = pop ? rptr_q + spp_pkg::FifoPtrW'(1) : rptr_q;
    count_d  = count_q + push_cnt - spp_pkg::FifoCntW'(pop);
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr0_en) begin
      mem_q[wptr_q] <= wr0_data;
    end
    if (wr1_en) begin
      mem_q[wptr_nx] <= sum_res_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  `SPP_ASSERT_IMP(a_no_overflow, push_cnt != '0, count_q + push_cnt <= spp_pkg::FifoCntW'(spp_pkg::FifoDepth))
  `SPP_ASSERT_IMP(a_ptr_count, 1'b1, spp_pkg::FifoPtrW'(wptr_q - rptr_q) == spp_pkg::FifoPtrW'(count_q))

endmodule

// ===== hdl/spp_core.sv =====
// ----------------------------------------------------------------------------
// spp_core
// input register and one-byte-per-cycle parse of the signature packet body, while the result queue has room
// ----------------------------------------------------------------------------
`include "signature_packet_parser_macros.svh"

module spp_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           body_byte_i,
  input  logic                 first_of_packet_i,
  input  logic                 last_of_packet_i,
  input  logic                 room_i,
  output spp_pkg::spp_push_t   push_o,
  output spp_pkg::spp_result_t val_res_o,
  output spp_pkg::spp_result_t sum_res_o
);

  // input register
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       first_q, last_q;
  logic       proc;

  // parse state
  spp_pkg::spp_phase_e phase_q, c_phase, n_phase;
  spp_pkg::spp_sub_e   sub_q, c_sub, n_sub;
  logic        unh_q, c_unh, n_unh;
  logic [3:0]  cnt_q, c_cnt, n_cnt;
  logic [15:0] area_q, c_area, n_area;
  logic [31:0] len_q, c_len, n_len;
  logic [7:0]  kind_q, c_kind, n_kind;
  logic [63:0] shift_q, c_shift, n_shift;
  logic [23:0] hdr_q, c_hdr, n_hdr;
  logic [31:0] time_q, c_time, n_time;
  logic [63:0] issuer_q, c_issuer, n_issuer;
  logic [15:0] check_q, c_check, n_check;
  logic [16:0] hlen_q, c_hlen, n_hlen;
  logic [13:0] vl_q, c_vl, n_vl;
  logic [2:0]  err_q, c_err, n_err;

  logic        hdr_done;
  spp_pkg::spp_sub_e hdr_next;
  logic        sub_end;
  logic        sub_fail;
  logic [16:0] bits_sum;
  logic        val_push;
  logic        val_final;
  logic [2:0]  status;

  assign proc       = in_valid_q && room_i;
  assign in_stall_o = in_valid_q && !room_i;

  // input register: refills whenever it is empty or being consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q  <= body_byte_i;
      first_q <= first_of_packet_i;
      last_q  <= last_of_packet_i;
    end
  end

  // next state for one byte
  always_comb begin
    // first of packet starts from a clean state
    c_phase  = first_q ? spp_pkg::PH_VER : phase_q;
    c_sub    = first_q ? spp_pkg::SUB_LEN0 : sub_q;
    c_unh    = first_q ? 1'b0 : unh_q;
    c_cnt    = first_q ? '0 : cnt_q;
    c_area   = first_q ? '0 : area_q;
    c_len    = first_q ? '0 : len_q;
    c_kind   = first_q ? '0 : kind_q;
    c_shift  = first_q ? '0 : shift_q;
    c_hdr    = first_q ? '0 : hdr_q;
    c_time   = first_q ? '0 : time_q;
    c_issuer = first_q ? '0 : issuer_q;
    c_check  = first_q ? '0 : check_q;
    c_hlen   = first_q ? '0 : hlen_q;
    c_vl     = first_q ? '0 : vl_q;
    c_err    = first_q ? spp_pkg::ST_OK : err_q;

    n_phase  = c_phase;
    n_sub    = c_sub;
    n_unh    = c_unh;
    n_area   = c_area;
    n_len    = c_len;
    n_kind   = c_kind;
    n_shift  = c_shift;
    n_hdr    = c_hdr;
    n_time   = c_time;
    n_issuer = c_issuer;
    n_check  = c_check;
    n_hlen   = c_hlen;
    n_vl     = c_vl;
    n_err    = c_err;

    // byte count saturates once the minimum body is reached
    n_cnt = (c_cnt == spp_pkg::MinBody) ? c_cnt : c_cnt + 4'd1;

    hdr_done  = 1'b0;
    hdr_next  = spp_pkg::SUB_KIND;
    sub_end   = 1'b0;
    sub_fail  = 1'b0;
    bits_sum  = '0;
    val_push  = 1'b0;
    val_final = 1'b0;

    case (c_phase)
      spp_pkg::PH_VER: begin
        if (byte_q != spp_pkg::VersionFour) begin
          n_err   = spp_pkg::ST_BAD_VERSION;
          n_phase = spp_pkg::PH_HALT;
        end else begin
          n_phase = spp_pkg::PH_TYPE;
        end
      end
      spp_pkg::PH_TYPE: begin
        n_hdr   = {byte_q, c_hdr[15:0]};
        n_phase = spp_pkg::PH_PKA;
      end
      spp_pkg::PH_PKA: begin
        n_hdr   = {c_hdr[23:16], byte_q, c_hdr[7:0]};
        n_phase = spp_pkg::PH_HASH;
      end
      spp_pkg::PH_HASH: begin
        n_hdr   = {c_hdr[23:8], byte_q};
        n_phase = spp_pkg::PH_HLEN0;
      end
      spp_pkg::PH_HLEN0: begin
        n_area  = {byte_q, 8'h00};
        n_phase = spp_pkg::PH_HLEN1;
      end
      spp_pkg::PH_ULEN0: begin
        n_area  = {byte_q, 8'h00};
        n_phase = spp_pkg::PH_ULEN1;
      end
      spp_pkg::PH_HLEN1: begin
        n_area = {c_area[15:8], byte_q};
        n_hlen = spp_pkg::HashedFixed + {1'b0, n_area};
        if (n_area != '0) begin
          n_phase = spp_pkg::PH_AREA;
          n_sub   = spp_pkg::SUB_LEN0;
          n_unh   = 1'b0;
        end else begin
          n_phase = spp_pkg::PH_ULEN0;
        end
      end
      spp_pkg::PH_ULEN1: begin
        n_area = {c_area[15:8], byte_q};
        if (n_area != '0) begin
          n_phase = spp_pkg::PH_AREA;
          n_sub   = spp_pkg::SUB_LEN0;
          n_unh   = 1'b1;
        end else begin
          n_phase = spp_pkg::PH_CHK0;
        end
      end
      spp_pkg::PH_AREA: begin
        n_area = c_area - 16'd1;
        // subpacket walk
        case (c_sub)
          spp_pkg::SUB_LEN0: begin
            n_kind   = '0;
            hdr_done = 1'b1;
            if (byte_q < spp_pkg::TwoOctetMark) begin
              n_len    = {24'h0, byte_q};
              hdr_next = spp_pkg::SUB_KIND;
            end else if (byte_q < spp_pkg::FiveOctetMark) begin
              n_len    = {16'h0, byte_q - spp_pkg::TwoOctetMark, 8'h00};
              hdr_next = spp_pkg::SUB_LEN2;
            end else begin
              n_len    = '0;
              hdr_next = spp_pkg::SUB_LEN5;
            end
          end
          spp_pkg::SUB_LEN2: begin
            n_len    = c_len + {24'h0, byte_q} + {24'h0, spp_pkg::TwoOctetMark};
            hdr_done = 1'b1;
            hdr_next = spp_pkg::SUB_KIND;
          end
          spp_pkg::SUB_LEN5: begin
            n_len    = {c_len[23:0], byte_q};
            n_kind   = c_kind + 8'd1;
            hdr_done = 1'b1;
            hdr_next = (n_kind >= {5'h0, spp_pkg::Len5Bytes}) ? spp_pkg::SUB_KIND
                                                              : spp_pkg::SUB_LEN5;
          end
          spp_pkg::SUB_KIND: begin
            // critical bit dropped
            n_kind = {1'b0, byte_q[6:0]};
            n_len  = c_len - 32'd1;
            if ((n_kind == spp_pkg::SubTime && n_len != 32'd4) ||
                (n_kind == spp_pkg::SubIssuer && n_len != 32'd8) ||
                (n_len > {16'h0, n_area})) begin
              sub_fail = 1'b1;
            end else if (n_len == '0) begin
              sub_end = 1'b1;
            end else begin
              n_shift = '0;
              n_sub   = spp_pkg::SUB_BODY;
            end
          end
          spp_pkg::SUB_BODY: begin
            n_shift = {c_shift[55:0], byte_q};
            n_len   = c_len - 32'd1;
            if (n_len == '0) begin
              if (c_kind == spp_pkg::SubTime) begin
                n_time = n_shift[31:0];
              end else if (c_kind == spp_pkg::SubIssuer) begin
                n_issuer = n_shift;
              end
              sub_end = 1'b1;
            end
          end
          default: begin
          end
        endcase

        // length header finished: check it against the area
        if (hdr_done) begin
          n_sub = hdr_next;
          if ((hdr_next == spp_pkg::SUB_KIND && n_len == '0) || n_area == '0) begin
            sub_fail = 1'b1;
          end
        end

        // subpacket finished: next one or leave the area
        if (sub_end) begin
          if (n_area == '0) begin
            n_phase = c_unh ? spp_pkg::PH_CHK0 : spp_pkg::PH_ULEN0;
          end else begin
            n_sub = spp_pkg::SUB_LEN0;
          end
        end

        if (sub_fail) begin
          n_err   = spp_pkg::ST_BAD_SUBLEN;
          n_phase = spp_pkg::PH_HALT;
        end
      end
      spp_pkg::PH_CHK0: begin
        n_check = {byte_q, 8'h00};
        n_phase = spp_pkg::PH_CHK1;
      end
      spp_pkg::PH_CHK1: begin
        n_check = {c_check[15:8], byte_q};
        if (c_hdr[15:8] != spp_pkg::AlgRsa) begin
          n_err   = spp_pkg::ST_BAD_ALG;
          n_phase = spp_pkg::PH_HALT;
        end else begin
          n_phase = spp_pkg::PH_BITS0;
        end
      end
      spp_pkg::PH_BITS0: begin
        // high byte of the bit count held until the low byte arrives
        n_vl    = {6'h0, byte_q};
        n_phase = spp_pkg::PH_BITS1;
      end
      spp_pkg::PH_BITS1: begin
        bits_sum = {1'b0, c_vl[7:0], byte_q} + 17'd7;
        n_vl     = bits_sum[16:3];
        n_phase  = (n_vl != '0) ? spp_pkg::PH_VALUE : spp_pkg::PH_DONE;
      end
      spp_pkg::PH_VALUE: begin
        val_push  = 1'b1;
        val_final = c_vl == 14'd1;
        n_vl      = c_vl - 14'd1;
        if (n_vl == '0) begin
          n_phase = spp_pkg::PH_DONE;
        end
      end
      default: begin
      end
    endcase

    // end of packet status
    if (n_cnt < spp_pkg::MinBody) begin
      status = spp_pkg::ST_SHORT;
    end else if (n_err != spp_pkg::ST_OK) begin
      status = n_err;
    end else if (n_phase == spp_pkg::PH_DONE) begin
      status = spp_pkg::ST_OK;
    end else if (n_phase == spp_pkg::PH_AREA) begin
      status = spp_pkg::ST_OVERRUN;
    end else begin
      status = spp_pkg::ST_SHORT;
    end
  end

  // result items
  always_comb begin
    val_res_o             = '0;
    val_res_o.kind        = spp_pkg::KIND_VALUE;
    val_res_o.value_byte  = byte_q;
    val_res_o.value_final = val_final;

    sum_res_o                  = '0;
    sum_res_o.kind             = spp_pkg::KIND_SUMMARY;
    sum_res_o.signature_class  = n_hdr[23:16];
    sum_res_o.key_algorithm    = n_hdr[15:8];
    sum_res_o.digest_algorithm = n_hdr[7:0];
    sum_res_o.made_at          = n_time;
    sum_res_o.issuer_id        = n_issuer;
    sum_res_o.quick_check      = n_check;
    sum_res_o.hashed_length    = n_hlen;
    sum_res_o.status           = status;

    push_o.value   = proc && val_push;
    push_o.summary = proc && last_q;
  end

  // state registers, cleared after the last byte of a packet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= spp_pkg::PH_VER;
      sub_q    <= spp_pkg::SUB_LEN0;
      unh_q    <= 1'b0;
      cnt_q    <= '0;
      area_q   <= '0;
      len_q    <= '0;
      kind_q   <= '0;
      shift_q  <= '0;
      hdr_q    <= '0;
      time_q   <= '0;
      issuer_q <= '0;
      check_q  <= '0;
      hlen_q   <= '0;
      vl_q     <= '0;
      err_q    <= spp_pkg::ST_OK;
    end else if (proc && last_q) begin
      phase_q  <= spp_pkg::PH_VER;
      sub_q    <= spp_pkg::SUB_LEN0;
      unh_q    <= 1'b0;
      cnt_q    <= '0;
      area_q   <= '0;
      len_q    <= '0;
      kind_q   <= '0;
      shift_q  <= '0;
      hdr_q    <= '0;
      time_q   <= '0;
      issuer_q <= '0;
      check_q  <= '0;
      hlen_q   <= '0;
      vl_q     <= '0;
      err_q    <= spp_pkg::ST_OK;
    end else if (proc) begin
      phase_q  <= n_phase;
      sub_q    <= n_sub;
      unh_q    <= n_unh;
      cnt_q    <= n_cnt;
      area_q   <= n_area;
      len_q    <= n_len;
      kind_q   <= n_kind;
      shift_q  <= n_shift;
      hdr_q    <= n_hdr;
      time_q   <= n_time;
      issuer_q <= n_issuer;
      check_q  <= n_check;
      hlen_q   <= n_hlen;
      vl_q     <= n_vl;
      err_q    <= n_err;
    end
  end

  `SPP_ASSERT_NXT(a_last_clears, proc && last_q, phase_q == spp_pkg::PH_VER && err_q == spp_pkg::ST_OK)
  `SPP_ASSERT_IMP(a_halt_has_error, phase_q == spp_pkg::PH_HALT, err_q != spp_pkg::ST_OK)
  `SPP_ASSERT_IMP(a_value_pending, phase_q == spp_pkg::PH_VALUE, vl_q != '0)

endmodule

// ===== hdl/signature_packet_parser.sv =====
// ----------------------------------------------------------------------------
// signature_packet_parser
// streaming parser for a version 4 signature packet body, one byte an item
// ----------------------------------------------------------------------------
//  channel  dir  handshake               payload
//  in       in   in_valid_i/in_stall_o   body_byte_i, first/last_of_packet_i
//  out      out  out_valid_o/out_stall_i result_kind_o .. status_o
//
//  while the result queue has room, one input item is parsed per cycle: input register, parse logic, result queue
//  an accepted byte passes the input register and then the result queue before its result reaches the output
//  the last byte of a packet yields a summary item after any value item
//  a four-entry result queue lets input flow while the output side stalls
//  reset is asynchronous, active low, and returns the parser to the version byte
// ----------------------------------------------------------------------------
module signature_packet_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  body_byte_i,
  input  logic        first_of_packet_i,
  input  logic        last_of_packet_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [7:0]  value_byte_o,
  output logic        value_final_o,
  output logic [7:0]  signature_class_o,
  output logic [7:0]  key_algorithm_o,
  output logic [7:0]  digest_algorithm_o,
  output logic [31:0] made_at_o,
  output logic [63:0] issuer_id_o,
  output logic [15:0] quick_check_o,
  output logic [16:0] hashed_length_o,
  output logic [2:0]  status_o
);

  spp_pkg::spp_push_t   push;
  spp_pkg::spp_result_t val_res, sum_res, out_res;
  logic                 room;

  // parser
  spp_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .body_byte_i       (body_byte_i),
    .first_of_packet_i (first_of_packet_i),
    .last_of_packet_i  (last_of_packet_i),
    .room_i            (room),
    .push_o            (push),
    .val_res_o         (val_res),
    .sum_res_o         (sum_res)
  );

  // result queue
  spp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .val_res_i   (val_res),
    .sum_res_i   (sum_res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  // result fields onto ports
  assign result_kind_o      = out_res.kind;
  assign value_byte_o       = out_res.value_byte;
  assign value_final_o      = out_res.value_final;
  assign signature_class_o  = out_res.signature_class;
  assign key_algorithm_o    = out_res.key_algorithm;
  assign digest_algorithm_o = out_res.digest_algorithm;
  assign made_at_o          = out_res.made_at;
  assign issuer_id_o        = out_res.issuer_id;
  assign quick_check_o      = out_res.quick_check;
  assign hashed_length_o    = out_res.hashed_length;
  assign status_o           = out_res.status;

endmodule
